// ===== hdl/mrc_pkg.sv =====
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types, constants and the CRC-16 byte update for the Modbus RTU
// response checker.
// ----------------------------------------------------------------------------
package mrc_pkg;

   localparam int MAX_FRAME_LEN = 256;
   localparam int COUNT_WIDTH   = $clog2(MAX_FRAME_LEN + 1);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = COUNT_WIDTH'(MAX_FRAME_LEN);
   localparam logic [COUNT_WIDTH-1:0] IDX_CRC_START = COUNT_WIDTH'(2);
   localparam logic [COUNT_WIDTH-1:0] IDX_READ_HIGH = COUNT_WIDTH'(3);
   localparam logic [COUNT_WIDTH-1:0] IDX_READ_LOW  = COUNT_WIDTH'(4);
   localparam logic [COUNT_WIDTH-1:0] IDX_MIN_LAST  = COUNT_WIDTH'(4);

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_CRC_ERROR = 2'd1;
   localparam logic [1:0] STATUS_TOO_SHORT = 2'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] level_value;
   } rsp_item_type;

   function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== hdl/mrc_frame_tracker.sv =====
// ----------------------------------------------------------------------------
// mrc_frame_tracker
// Per-frame state: running CRC, byte count, two-byte delay line and the
// captured reading. Forms the result for the final byte of a frame.
// ----------------------------------------------------------------------------
module mrc_frame_tracker
   import mrc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  req_item_type item,
   output rsp_item_type result
);

   logic [15:0]            crc_ff, crc_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [15:0]            delayed_ff, delayed_in;
   logic [15:0]            reading_ff, reading_in;

   logic [15:0] crc_cur;
   logic [15:0] reading_cur;
   logic [15:0] received;

   always_comb begin
      crc_cur = (count_ff >= IDX_CRC_START) ? crc_feed(crc_ff, delayed_ff[15:8]) : crc_ff;

      reading_cur = reading_ff;
      if (count_ff == IDX_READ_HIGH) begin
         reading_cur = {item.data_byte, reading_ff[7:0]};
      end else if (count_ff == IDX_READ_LOW) begin
         reading_cur = {reading_ff[15:8], item.data_byte};
      end

      received = {item.data_byte, delayed_ff[7:0]};

      if (count_ff < IDX_MIN_LAST) begin
         result.status      = STATUS_TOO_SHORT;
         result.level_value = 16'h0000;
      end else if (received != crc_cur) begin
         result.status      = STATUS_CRC_ERROR;
         result.level_value = 16'h0000;
      end else begin
         result.status      = STATUS_OK;
         result.level_value = reading_cur;
      end

      if (item.last_byte) begin
         crc_in     = CRC_INIT;
         count_in   = '0;
         delayed_in = 16'h0000;
         reading_in = 16'h0000;
      end else begin
         crc_in     = crc_cur;
         count_in   = (count_ff < COUNT_MAX) ? count_ff + 1'b1 : count_ff;
         delayed_in = {delayed_ff[7:0], item.data_byte};
         reading_in = reading_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff     <= CRC_INIT;
         count_ff   <= '0;
         delayed_ff <= 16'h0000;
         reading_ff <= 16'h0000;
      end else if (advance) begin
         crc_ff     <= crc_in;
         count_ff   <= count_in;
         delayed_ff <= delayed_in;
         reading_ff <= reading_in;
      end
   end

endmodule

// ===== hdl/modbus_response_crc_checker_core.sv =====
// ----------------------------------------------------------------------------
// modbus_response_crc_checker_core
// Checks Modbus RTU response frames byte by byte and reports CRC status and
// the 16-bit reading held in bytes 3 and 4.
//
// Usage:
//   req_ channel: one frame byte per item, last_byte set on the final byte.
//   rsp_ channel: one item per frame, issued for the final byte only:
//     status 0 ok (level_value = bytes 3 and 4, byte 3 high),
//     status 1 CRC mismatch, status 2 frame shorter than five bytes;
//     level_value is zero on any error.
//   Throughput: one byte per cycle while no result waits on rsp_ready; the CRC
//   takes a whole byte at once from the input register.
//   Output: a final byte's result is held in the result register (rsp_valid).
//   Stall: a result waiting on rsp_ready holds only a final byte in the
//   input register; other bytes keep flowing, and the input register plus
//   result register let the next byte be taken while a result waits.
//   Reset: frame state returns to CRC 0xFFFF, count zero; both registers
//   are emptied. State also returns to reset after every final byte.
// ----------------------------------------------------------------------------
module modbus_response_crc_checker_core
   import mrc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;

   logic         out_free;
   logic         advance;
   rsp_item_type result;

   assign out_free     = !out_valid_ff || rsp_ready;
   assign advance      = in_valid_ff && (!in_item_ff.last_byte || out_free);
   assign req_ready    = !in_valid_ff || advance;
   assign in_valid_in  = req_valid || (in_valid_ff && !advance);
   assign out_valid_in = (advance && in_item_ff.last_byte) || (out_valid_ff && !rsp_ready);

   mrc_frame_tracker u_tracker (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_item_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_item;
      end
      if (advance && in_item_ff.last_byte) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives Modbus RTU response frames byte by byte into the CRC checker and
// checks every status and reading against a frame tracker kept in step with
// the accepted bytes. Directed frames cover the short, minimal, extreme-value
// and mismatch cases. Random frames follow, mostly well-formed with a few
// corrupted, short, noisy and overlong ones. Random idling runs on both
// channels, and one long result hold-off fills the block and stalls its input.
// ----------------------------------------------------------------------------
module testbench;
   import mrc_pkg::*;

   localparam int ITEM_TARGET  = 1700;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 400;
   localparam int DRAIN_CYCLES = 20;
   localparam int SHORT_LIMIT  = 4;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_item;

   req_item_type byte_queue[$];
   rsp_item_type status_reports[$];
   logic [7:0]   frame_buf[$];

   logic [15:0]  trk_crc   = 16'hFFFF;
   logic [8:0]   trk_count = '0;
   logic [15:0]  trk_delay = '0;
   logic [15:0]  trk_hold  = '0;

   int total_items = 0;
   int n_sent      = 0;
   int n_cycles    = 0;
   int n_faults    = 0;
   int n_stalls    = 0;
   int n_ok        = 0;
   int n_crc_err   = 0;
   int n_short     = 0;
   int n_overlong  = 0;
   int hold_left   = 0;
   bit hold_done   = 1'b0;
   int send_idle;
   int recv_idle;

   modbus_response_crc_checker_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   always #1 clock = ~clock;

   always_comb begin
      if (n_sent < total_items / 3) begin
         send_idle = 38;
         recv_idle = 53;
      end else if (n_sent < 2 * total_items / 3) begin
         send_idle = 53;
         recv_idle = 38;
      end else begin
         send_idle = 0;
         recv_idle = 0;
      end
   end

   function automatic logic [15:0] crc16_byte(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] v;
      v = {acc[15:8], acc[7:0] ^ b};
      repeat (8) begin
         v = v[0] ? ({1'b0, v[15:1]} ^ 16'hA001) : {1'b0, v[15:1]};
      end
      return v;
   endfunction

   // advance the frame tracker by one accepted item
   task automatic track_frame_byte(input req_item_type it);
      rsp_item_type r;
      logic [15:0]  rx_crc;
      if (trk_count >= 2) begin
         trk_crc = crc16_byte(trk_crc, trk_delay[15:8]);
      end
      if (trk_count == 3) begin
         trk_hold[15:8] = it.data_byte;
      end else if (trk_count == 4) begin
         trk_hold[7:0] = it.data_byte;
      end
      if (!it.last_byte) begin
         trk_delay = {trk_delay[7:0], it.data_byte};
         if (trk_count < MAX_FRAME_LEN) begin
            trk_count = trk_count + 1'b1;
         end
      end else begin
         rx_crc = {it.data_byte, trk_delay[7:0]};
         if (trk_count < SHORT_LIMIT) begin
            r.status      = STATUS_TOO_SHORT;
            r.level_value = '0;
            n_short++;
         end else if (rx_crc != trk_crc) begin
            r.status      = STATUS_CRC_ERROR;
            r.level_value = '0;
            n_crc_err++;
         end else begin
            r.status      = STATUS_OK;
            r.level_value = trk_hold;
            n_ok++;
         end
         status_reports.push_back(r);
         trk_crc   = 16'hFFFF;
         trk_count = '0;
         trk_delay = '0;
         trk_hold  = '0;
      end
   endtask

   task automatic fill_random(input int n);
      repeat (n) frame_buf.push_back(8'($urandom_range(255)));
   endtask

   task automatic append_crc();
      logic [15:0] c;
      c = 16'hFFFF;
      foreach (frame_buf[i]) c = crc16_byte(c, frame_buf[i]);
      frame_buf.push_back(c[7:0]);
      frame_buf.push_back(c[15:8]);
   endtask

   task automatic queue_frame();
      req_item_type it;
      foreach (frame_buf[i]) begin
         it.data_byte = frame_buf[i];
         it.last_byte = (i == frame_buf.size() - 1);
         byte_queue.push_back(it);
      end
      frame_buf.delete();
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            track_frame_byte(req_item);
            n_sent <= n_sent + 1;
         end else if (req_valid) begin
            n_stalls <= n_stalls + 1;
         end
         if (!req_valid || req_ready) begin
            if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
               req_item  <= byte_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (status_reports.size() == 0) begin
               if (n_faults < 10) begin
                  $display("unexpected result: status %0d level %h",
                           rsp_item.status, rsp_item.level_value);
               end
               n_faults++;
            end else begin
               want = status_reports.pop_front();
               if (rsp_item.status != want.status
                   || rsp_item.level_value != want.level_value) begin
                  if (n_faults < 10) begin
                     $display("mismatch: status %0d/%0d level %h/%h (expected/actual)",
                              want.status, rsp_item.status,
                              want.level_value, rsp_item.level_value);
                  end
                  n_faults++;
               end
            end
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else if (!hold_done && total_items > 0 && n_sent >= 5 * total_items / 6) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   always @(posedge clock) begin
      n_cycles <= n_cycles + 1;
      if (n_cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", n_cycles);
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      int n_frames;
      int pick;
      int len;
      int pos;

      // short frames
      frame_buf = '{8'hFF};
      queue_frame();
      frame_buf = '{8'h00, 8'hFF};
      queue_frame();
      frame_buf = '{8'hFF, 8'h00, 8'hFF, 8'h00};
      queue_frame();
      // minimal good frame, reading taken from the CRC bytes
      frame_buf = '{8'hFF, 8'hFF, 8'hFF};
      append_crc();
      queue_frame();
      // good frame with full-scale reading
      frame_buf = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF};
      append_crc();
      queue_frame();
      // minimal frame with a corrupted CRC
      frame_buf = '{8'h00, 8'h00, 8'h00};
      append_crc();
      frame_buf[4] ^= 8'h80;
      queue_frame();

      n_frames = 0;
      while (byte_queue.size() < ITEM_TARGET) begin
         n_frames++;
         pick = $urandom_range(99);
         if (n_frames == 30 || n_frames == 90) begin
            len = $urandom_range(250, 300);
            if (len > MAX_FRAME_LEN) n_overlong++;
            fill_random(len - 2);
            append_crc();
         end else if (pick < 65) begin
            fill_random($urandom_range(3, 14));
            append_crc();
         end else if (pick < 80) begin
            fill_random($urandom_range(3, 14));
            append_crc();
            pos = $urandom_range(frame_buf.size() - 1);
            frame_buf[pos] ^= 8'(1 << $urandom_range(7));
         end else if (pick < 88) begin
            fill_random($urandom_range(1, 4));
         end else begin
            fill_random($urandom_range(1, 12));
         end
         queue_frame();
      end
      total_items = byte_queue.size();

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      while (byte_queue.size() > 0 || req_valid) @(posedge clock);
      while (status_reports.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (status_reports.size() > 0) begin
         n_faults += status_reports.size();
      end
      $display("%0d bytes in %0d frames (%0d overlong); %0d input stall cycles",
               n_sent, n_ok + n_crc_err + n_short, n_overlong, n_stalls);
      $display("results: %0d ok, %0d crc mismatch, %0d too short; %0d faults",
               n_ok, n_crc_err, n_short, n_faults);
      if (n_faults == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
